// File: hdl/ssep_pkg.sv
package ssep_pkg;

  // Fixed field widths of the stream items.
  localparam int VALUE_W     = 8;
  localparam int TOTAL_W     = 12;
  localparam int OUT_TDATA_W = 16;

  // Geometry of one word of the reachable-sum bitset.
  localparam int WORD_W  = 64;
  localparam int WORD_SH = 6;
  localparam int SHIFT_W = VALUE_W - WORD_SH;

  // Sequencer states.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SWEEP,
    ST_DRAIN,
    ST_QUERY,
    ST_REPORT
  } state_e;

  // Write-side control of the bitset memory.
  typedef struct packed {
    logic wr_en;
    logic clr;
  } mem_ctl_t;

endpackage

// File: hdl/ssep_bitmem.sv
module ssep_bitmem #(
  parameter int DEPTH = 32,
  parameter int AW    = 5
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  ssep_pkg::mem_ctl_t            ctl_i,
  input  logic [AW-1:0]                 rd_a_addr_i,
  input  logic [AW-1:0]                 rd_b_addr_i,
  input  logic [AW-1:0]                 wr_addr_i,
  input  logic [ssep_pkg::WORD_W-1:0]   wr_data_i,
  output logic [ssep_pkg::WORD_W-1:0]   rd_a_data_o,
  output logic [ssep_pkg::WORD_W-1:0]   rd_b_data_o
);

  logic [ssep_pkg::WORD_W-1:0] mem [DEPTH];
  logic [DEPTH-1:0]            valid_q;
  logic                        va_q;
  logic                        vb_q;
  logic [ssep_pkg::WORD_W-1:0] ra_q;
  logic [ssep_pkg::WORD_W-1:0] rb_q;
  logic [AW-1:0]               aaddr_q;
  logic [AW-1:0]               baddr_q;

  // Storage array with one write and two registered reads per cycle.
  always_ff @(posedge clk_i) begin
    if (ctl_i.wr_en) begin
      mem[wr_addr_i] <= wr_data_i;
    end
    ra_q    <= mem[rd_a_addr_i];
    rb_q    <= mem[rd_b_addr_i];
    aaddr_q <= rd_a_addr_i;
    baddr_q <= rd_b_addr_i;
  end

  // Valid bits: a word never written since the last clear reads as its reset value.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
      va_q    <= 1'b0;
      vb_q    <= 1'b0;
    end else begin
      va_q <= valid_q[rd_a_addr_i];
      vb_q <= valid_q[rd_b_addr_i];
      if (ctl_i.clr) begin
        valid_q <= '0;
      end else if (ctl_i.wr_en) begin
        valid_q[wr_addr_i] <= 1'b1;
      end
    end
  end

  // Only sum zero is reachable in a cleared set.
  assign rd_a_data_o = va_q ? ra_q :
                       ((aaddr_q == '0) ? ssep_pkg::WORD_W'(1) : '0);
  assign rd_b_data_o = vb_q ? rb_q :
                       ((baddr_q == '0) ? ssep_pkg::WORD_W'(1) : '0);

endmodule

// File: hdl/ssep_shift_unit.sv
module ssep_shift_unit #(
  parameter int TOP_BITS = 64
) (
  input  logic [ssep_pkg::WORD_W-1:0]  dst_i,
  input  logic [ssep_pkg::WORD_W-1:0]  hi_i,
  input  logic [ssep_pkg::WORD_W-1:0]  lo_i,
  input  logic [ssep_pkg::WORD_SH-1:0] bit_sh_i,
  input  logic                         top_i,
  output logic [ssep_pkg::WORD_W-1:0]  new_o
);

  localparam logic [ssep_pkg::WORD_W-1:0] TOP_MASK =
    (TOP_BITS >= ssep_pkg::WORD_W) ? '1 :
    ((ssep_pkg::WORD_W'(1) << TOP_BITS) - ssep_pkg::WORD_W'(1));

  logic [2*ssep_pkg::WORD_W-1:0] cat;
  logic [ssep_pkg::WORD_W-1:0]   merged;

  // Funnel shift of two adjacent source words, ORed into the destination word.
  always_comb begin
    cat    = {hi_i, lo_i} << bit_sh_i;
    merged = dst_i | cat[2*ssep_pkg::WORD_W-1:ssep_pkg::WORD_W];
    // Sums beyond half the maximum total are dropped in the top word.
    new_o  = top_i ? (merged & TOP_MASK) : merged;
  end

endmodule

// File: hdl/subset_sum_equal_partition.sv
// Equal-partition checker: values stream in one per item on the slave side, the last
// one of a set marked by tlast; after the last item one result gives whether the set
// splits into two halves of equal sum, the overflow flag and the saturated total. The
// reachable sums up to half of MAX_TOTAL live in a memory of 64-bit words that one
// funnel-shift unit updates one word per cycle. An item whose value is nonzero and
// below the bitset size is swept through every word and drained before ready returns,
// so no new item is taken while it is in flight; a zero or oversized value skips the
// sweep. The last item of a set then passes the query state for the final lookup and
// the report state for the result load, and the result register lets the set's state
// clear as soon as the previous result has been taken. The sweep's pace is set by the
// memory's two read ports, which deliver one destination and one source word per cycle.
module subset_sum_equal_partition #(
  parameter int MAX_TOTAL = 4095,
  parameter int VALUE_MAX = 255
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  // tdata: value[7:0]
  input  logic [ssep_pkg::VALUE_W-1:0]       s_axis_tdata_i,
  input  logic                               s_axis_tlast_i,
  input  logic                               s_axis_tvalid_i,
  output logic                               s_axis_tready_o,
  // tdata: possible[0], overflow[1], total[13:2], zero fill[15:14]
  output logic [ssep_pkg::OUT_TDATA_W-1:0]   m_axis_tdata_o,
  output logic                               m_axis_tvalid_o,
  input  logic                               m_axis_tready_i
);

  localparam int REACH_BITS = MAX_TOTAL / 2 + 1;
  localparam int WORDS      = (REACH_BITS + ssep_pkg::WORD_W - 1) / ssep_pkg::WORD_W;
  localparam int AW         = (WORDS > 1) ? $clog2(WORDS) : 1;
  localparam int CW         = $clog2(WORDS + 1);
  localparam int IW         = AW + 3;
  localparam int TOP_BITS   = REACH_BITS - (WORDS - 1) * ssep_pkg::WORD_W;
  localparam int TOT_W      = $clog2(MAX_TOTAL + 1);
  localparam int SW         = ((TOT_W > ssep_pkg::VALUE_W) ? TOT_W : ssep_pkg::VALUE_W) + 1;

  ssep_pkg::state_e state_q, state_d;

  logic [CW-1:0]                    cnt_q, cnt_d;
  logic [ssep_pkg::SHIFT_W-1:0]     wsh_q;
  logic [ssep_pkg::WORD_SH-1:0]     bsh_q;
  logic                             last_q;
  logic [TOT_W-1:0]                 total_q, total_d;
  logic                             ovf_q, ovf_d;
  logic                             b_ret_q;
  logic                             w_ret_q;
  logic                             b_zero_q;
  logic [AW-1:0]                    wa_q;
  logic [ssep_pkg::WORD_W-1:0]      hi_q;
  logic                             out_vld_q;
  logic                             out_poss_q;
  logic                             out_ovf_q;
  logic [ssep_pkg::TOTAL_W-1:0]     out_total_q;

  logic                             accept;
  logic                             load_out;
  logic [ssep_pkg::VALUE_W-1:0]     v_sat;
  logic                             skip;
  logic [SW-1:0]                    sum;
  logic signed [IW-1:0]             src_s;
  logic                             src_neg;
  logic [AW-1:0]                    rd_a_addr;
  logic [AW-1:0]                    rd_b_addr;
  logic [AW-1:0]                    q_idx;
  logic [ssep_pkg::WORD_W-1:0]      a_data;
  logic [ssep_pkg::WORD_W-1:0]      b_data;
  logic [ssep_pkg::WORD_W-1:0]      lo_eff;
  logic [ssep_pkg::WORD_W-1:0]      new_word;
  logic                             q_bit;
  ssep_pkg::mem_ctl_t               mem_ctl;

  // Input value clipped to the supported maximum, and the saturating running total.
  always_comb begin
    v_sat = (32'(s_axis_tdata_i) > 32'(VALUE_MAX)) ?
            ssep_pkg::VALUE_W'(VALUE_MAX) : s_axis_tdata_i;
    skip  = (v_sat == '0) || (32'(v_sat) >= 32'(REACH_BITS));
    sum   = SW'(total_q) + SW'(v_sat);
    if (32'(sum) > 32'(MAX_TOTAL)) begin
      total_d = TOT_W'(MAX_TOTAL);
      ovf_d   = 1'b1;
    end else begin
      total_d = TOT_W'(sum);
      ovf_d   = ovf_q;
    end
  end

  // Source word for the current issue step, counted downward with the destination.
  always_comb begin
    src_s   = IW'(WORDS - 1) - IW'(wsh_q) - IW'(cnt_q);
    src_neg = src_s[IW-1];
    q_idx   = AW'(total_q >> (ssep_pkg::WORD_SH + 1));
  end

  // Sequencer: next state and memory addressing.
  always_comb begin
    state_d   = state_q;
    cnt_d     = cnt_q;
    accept    = 1'b0;
    load_out  = 1'b0;
    rd_a_addr = '0;
    rd_b_addr = src_neg ? '0 : src_s[AW-1:0];
    case (state_q)
      ssep_pkg::ST_IDLE: begin
        cnt_d = '0;
        if (s_axis_tvalid_i) begin
          accept = 1'b1;
          if (!skip) begin
            state_d = ssep_pkg::ST_SWEEP;
          end else if (s_axis_tlast_i) begin
            state_d = ssep_pkg::ST_QUERY;
          end
        end
      end
      ssep_pkg::ST_SWEEP: begin
        if (cnt_q != '0) begin
          rd_a_addr = AW'(CW'(WORDS) - cnt_q);
        end
        cnt_d = cnt_q + CW'(1);
        if (cnt_q == CW'(WORDS)) begin
          state_d = ssep_pkg::ST_DRAIN;
        end
      end
      ssep_pkg::ST_DRAIN: begin
        state_d = last_q ? ssep_pkg::ST_QUERY : ssep_pkg::ST_IDLE;
      end
      ssep_pkg::ST_QUERY: begin
        rd_a_addr = q_idx;
        state_d   = ssep_pkg::ST_REPORT;
      end
      ssep_pkg::ST_REPORT: begin
        // Keep reading the queried word so the lookup holds while the result waits.
        rd_a_addr = q_idx;
        if (!out_vld_q || m_axis_tready_i) begin
          load_out = 1'b1;
          state_d  = ssep_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = ssep_pkg::ST_IDLE;
      end
    endcase
  end

  assign s_axis_tready_o = (state_q == ssep_pkg::ST_IDLE);

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ssep_pkg::ST_IDLE;
      cnt_q     <= '0;
      total_q   <= '0;
      ovf_q     <= 1'b0;
      last_q    <= 1'b0;
      b_ret_q   <= 1'b0;
      w_ret_q   <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      b_ret_q <= (state_q == ssep_pkg::ST_SWEEP);
      w_ret_q <= (state_q == ssep_pkg::ST_SWEEP) && (cnt_q != '0);
      if (accept) begin
        total_q <= total_d;
        ovf_q   <= ovf_d;
        last_q  <= s_axis_tlast_i;
      end else if (load_out) begin
        total_q <= '0;
        ovf_q   <= 1'b0;
      end
      if (load_out) begin
        out_vld_q <= 1'b1;
      end else if (m_axis_tready_i) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  // Payload registers: shift amounts, pipeline tags and the result word.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      wsh_q <= v_sat[ssep_pkg::VALUE_W-1:ssep_pkg::WORD_SH];
      bsh_q <= v_sat[ssep_pkg::WORD_SH-1:0];
    end
    b_zero_q <= src_neg;
    wa_q     <= AW'(CW'(WORDS) - cnt_q);
    if (b_ret_q) begin
      hi_q <= lo_eff;
    end
    if (load_out) begin
      out_poss_q  <= !ovf_q && !total_q[0] && q_bit;
      out_ovf_q   <= ovf_q;
      out_total_q <= ssep_pkg::TOTAL_W'(total_q);
    end
  end

  assign lo_eff = b_zero_q ? '0 : b_data;
  assign q_bit  = a_data[ssep_pkg::WORD_SH'(total_q >> 1)];

  assign mem_ctl.wr_en = w_ret_q;
  assign mem_ctl.clr   = load_out;

  ssep_bitmem #(
    .DEPTH(WORDS),
    .AW   (AW)
  ) u_bitmem (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .ctl_i      (mem_ctl),
    .rd_a_addr_i(rd_a_addr),
    .rd_b_addr_i(rd_b_addr),
    .wr_addr_i  (wa_q),
    .wr_data_i  (new_word),
    .rd_a_data_o(a_data),
    .rd_b_data_o(b_data)
  );

  ssep_shift_unit #(
    .TOP_BITS(TOP_BITS)
  ) u_shift (
    .dst_i   (a_data),
    .hi_i    (hi_q),
    .lo_i    (lo_eff),
    .bit_sh_i(bsh_q),
    .top_i   (wa_q == AW'(WORDS - 1)),
    .new_o   (new_word)
  );

  assign m_axis_tvalid_o = out_vld_q;
  assign m_axis_tdata_o  = ssep_pkg::OUT_TDATA_W'({out_total_q, out_ovf_q, out_poss_q});

  // A set reported as splittable has neither overflowed nor an odd total.
  a_poss_consistent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_vld_q && out_poss_q) |-> (!out_ovf_q && !out_total_q[0]))
    else $error("possible reported with overflow or odd total");

  // An overflowed set always reports the saturated total.
  a_ovf_saturated: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && ovf_d) |=> (total_q == TOT_W'(MAX_TOTAL)))
    else $error("overflowed total not saturated");

  // Writes of the sweep land only inside the bitset and never while idle.
  a_write_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mem_ctl.wr_en |-> ((32'(wa_q) < 32'(WORDS)) && (state_q != ssep_pkg::ST_IDLE)))
    else $error("bitset write out of range or while idle");

  // After a result is loaded the set's state starts over.
  a_clear_after_report: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load_out |=> (total_q == '0 && !ovf_q && out_vld_q))
    else $error("set state not cleared after report");

endmodule

// File: sim/subset_sum_equal_partition_tb.sv
`timescale 1ns / 1ps

module subset_sum_equal_partition_tb;

  localparam int MAX_TOTAL    = 4095;
  localparam int REACH_BITS   = MAX_TOTAL / 2 + 1;
  localparam int RANDOM_ITEMS = 1650;
  localparam int DRAIN_CYCLES = 64;

  // One result item as the checker sees it.
  typedef struct packed {
    logic                         possible;
    logic                         overflow;
    logic [ssep_pkg::TOTAL_W-1:0] total;
  } partition_result_t;

  // One row of the directed table; a row repeats its item reps times.
  typedef struct packed {
    logic [ssep_pkg::VALUE_W-1:0] value;
    logic                         last;
    logic [4:0]                   reps;
    logic                         known;
    partition_result_t            result;
  } stim_row_t;

  logic                             clk_i = 1'b0;
  logic                             rst_n = 1'b0;
  logic [ssep_pkg::VALUE_W-1:0]     item_value = '0;
  logic                             item_last = 1'b0;
  logic                             item_valid = 1'b0;
  logic                             item_ready;
  logic [ssep_pkg::OUT_TDATA_W-1:0] result_data;
  logic                             result_valid;
  logic                             result_ready = 1'b0;

  // Model of the partition checker: reachable half-sums, saturated total and flag.
  logic [REACH_BITS-1:0]  reach_sums = 1;
  int unsigned            set_total = 0;
  logic                   set_overflow = 1'b0;
  partition_result_t      expected_results_q[$];
  int                     mismatch_count = 0;

  // Burst modes turn idling off on one side for a while.
  bit                     sender_burst = 1'b0;
  bit                     receiver_burst = 1'b0;
  int                     stall_left = 0;

  subset_sum_equal_partition u_top (
    .clk_i           (clk_i),
    .rst_ni          (rst_n),
    .s_axis_tdata_i  (item_value),
    .s_axis_tlast_i  (item_last),
    .s_axis_tvalid_i (item_valid),
    .s_axis_tready_o (item_ready),
    .m_axis_tdata_o  (result_data),
    .m_axis_tvalid_o (result_valid),
    .m_axis_tready_i (result_ready)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Adds one value to the model; returns 1 with the set's result on the last item.
  function automatic bit absorb_value(input logic [ssep_pkg::VALUE_W-1:0] value,
                                      input logic last,
                                      output partition_result_t res);
    reach_sums = reach_sums | (reach_sums << value);
    if (set_total + value > MAX_TOTAL) begin
      set_total    = MAX_TOTAL;
      set_overflow = 1'b1;
    end else begin
      set_total += value;
    end
    res.possible = !set_overflow && (set_total % 2 == 0) && reach_sums[set_total / 2];
    res.overflow = set_overflow;
    res.total    = ssep_pkg::TOTAL_W'(set_total);
    if (last) begin
      reach_sums   = 1;
      set_total    = 0;
      set_overflow = 1'b0;
    end
    return last;
  endfunction

  // Offers one item after a random gap and waits for the handshake.
  task automatic send_item(input logic [ssep_pkg::VALUE_W-1:0] value, input logic last,
                           input logic known, input partition_result_t known_res);
    int gap;
    int roll;
    partition_result_t res;
    gap = 0;
    if (!sender_burst) begin
      roll = $urandom_range(99);
      if (roll < 55) gap = 0;
      else if (roll < 85) gap = $urandom_range(1, 3);
      else if (roll < 97) gap = $urandom_range(4, 12);
      else gap = $urandom_range(20, 60);
    end
    if (gap > 0) begin
      item_valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    item_valid <= 1'b1;
    item_value <= value;
    item_last  <= last;
    do @(posedge clk_i); while (!item_ready);
    if (absorb_value(value, last, res)) begin
      expected_results_q.insert(expected_results_q.size(), known ? known_res : res);
    end
  endtask

  // Result side: compare each accepted item and apply random backpressure.
  always @(posedge clk_i) begin : result_check
    partition_result_t got;
    partition_result_t want;
    int roll;
    if (rst_n && result_valid && result_ready) begin
      got.possible = result_data[0];
      got.overflow = result_data[1];
      got.total    = result_data[2 +: ssep_pkg::TOTAL_W];
      if (expected_results_q.size() == 0) begin
        $display("%0t: unexpected result possible=%0b overflow=%0b total=%0d",
                 $time, got.possible, got.overflow, got.total);
        mismatch_count++;
      end else begin
        want = expected_results_q.pop_front();
        if (got !== want) begin
          $display("%0t: mismatch expected possible=%0b overflow=%0b total=%0d",
                   $time, want.possible, want.overflow, want.total);
          $display("%0t:          actual   possible=%0b overflow=%0b total=%0d",
                   $time, got.possible, got.overflow, got.total);
          mismatch_count++;
        end
      end
    end
    if (stall_left > 0) begin
      result_ready <= 1'b0;
      stall_left--;
    end else if (!receiver_burst && $urandom_range(99) < 20) begin
      roll = $urandom_range(99);
      if (roll < 80) stall_left = $urandom_range(1, 3);
      else if (roll < 96) stall_left = $urandom_range(4, 12);
      else stall_left = $urandom_range(20, 60);
      stall_left--;
      result_ready <= 1'b0;
    end else begin
      result_ready <= 1'b1;
    end
    if ($urandom_range(499) == 0) receiver_burst = !receiver_burst;
  end

  initial begin : stimulus
    stim_row_t rows [11];
    int sent;
    int kind;
    int len;
    int lo;
    int hi;
    logic [ssep_pkg::VALUE_W-1:0] value;
    // Directed sets: lone zero, lone maximum, equal pair, small partition,
    // zero value with odd total, and a set that runs past the total bound.
    rows = '{
      '{8'd0,   1'b1, 5'd1,  1'b1, '{1'b1, 1'b0, 12'd0}},
      '{8'd255, 1'b1, 5'd1,  1'b1, '{1'b0, 1'b0, 12'd255}},
      '{8'd255, 1'b0, 5'd1,  1'b0, '{1'b0, 1'b0, 12'd0}},
      '{8'd255, 1'b1, 5'd1,  1'b1, '{1'b1, 1'b0, 12'd510}},
      '{8'd1,   1'b0, 5'd1,  1'b0, '{1'b0, 1'b0, 12'd0}},
      '{8'd2,   1'b0, 5'd1,  1'b0, '{1'b0, 1'b0, 12'd0}},
      '{8'd3,   1'b1, 5'd1,  1'b0, '{1'b0, 1'b0, 12'd0}},
      '{8'd0,   1'b0, 5'd1,  1'b0, '{1'b0, 1'b0, 12'd0}},
      '{8'd7,   1'b1, 5'd1,  1'b1, '{1'b0, 1'b0, 12'd7}},
      '{8'd255, 1'b0, 5'd16, 1'b0, '{1'b0, 1'b0, 12'd0}},
      '{8'd16,  1'b1, 5'd1,  1'b1, '{1'b0, 1'b1, 12'd4095}}
    };
    repeat (5) @(posedge clk_i);
    rst_n <= 1'b1;
    @(posedge clk_i);
    foreach (rows[r]) begin
      repeat (rows[r].reps) send_item(rows[r].value, rows[r].last, rows[r].known,
                                      rows[r].result);
    end

    // Random sets: wide values, small values that often split evenly, heavy sets
    // that often overflow, all-zero sets, and sets that land right around the bound.
    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      kind         = $urandom_range(99);
      sender_burst = ($urandom_range(3) == 0);
      lo           = 0;
      hi           = 255;
      if (kind < 45) begin
        len = $urandom_range(1, 8);
      end else if (kind < 75) begin
        len = $urandom_range(3, 12);
        hi  = 31;
      end else if (kind < 90) begin
        len = $urandom_range(14, 20);
        lo  = 200;
      end else if (kind < 95) begin
        len = $urandom_range(1, 4);
        hi  = 0;
      end else begin
        len = 17;
      end
      for (int k = 0; k < len; k++) begin
        if (kind >= 95) begin
          value = (k < 16) ? 8'd255 : ssep_pkg::VALUE_W'($urandom_range(0, 20));
        end else begin
          value = ssep_pkg::VALUE_W'($urandom_range(lo, hi));
        end
        send_item(value, k == len - 1, 1'b0, '0);
      end
      sent += len;
    end
    item_valid <= 1'b0;

    while (expected_results_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("** subset_sum_equal_partition: PASSED **");
    end else begin
      $display("** subset_sum_equal_partition: FAILED **");
    end
    $finish;
  end

  // Watchdog well past the slowest legal run.
  initial begin
    #20_000_000;
    $display("** subset_sum_equal_partition: FAILED **");
    $finish;
  end

endmodule

// File: subset_sum_equal_partition.f
hdl/ssep_pkg.sv
hdl/ssep_bitmem.sv
hdl/ssep_shift_unit.sv
hdl/subset_sum_equal_partition.sv
sim/subset_sum_equal_partition_tb.sv
